[rtl/core/sdsp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdsp_pkg
// Shared types, codes and the SIXBIT name decoder for the directory segment
// parser.
// ----------------------------------------------------------------------------
package sdsp_pkg;

	localparam int MAX_SEGMENTS_DEF = 6;
	localparam int RES_DEPTH        = 4;
	localparam int PTR_W            = $clog2(RES_DEPTH);
	localparam int CNT_W            = PTR_W + 1;

	// configuration register indexes
	localparam logic [1:0] CFG_PARTITION_OFFSET = 2'd0;
	localparam logic [1:0] CFG_MATCH_NAME       = 2'd1;
	localparam logic [1:0] CFG_MATCH_ENABLE     = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_FILE    = 2'd0;
	localparam logic [1:0] KIND_EMPTY   = 2'd1;
	localparam logic [1:0] KIND_SEG_END = 2'd2;

	typedef enum logic [2:0] {
		PH_HEADER    = 3'd0,
		PH_ENTRY     = 3'd1,
		PH_EMPTY_LEN = 3'd2,
		PH_NAME      = 3'd3,
		PH_EXTRA     = 3'd4,
		PH_LENGTH    = 3'd5,
		PH_IDLE      = 3'd6
	} phase_t;

	typedef struct packed {
		logic        last;
		logic        walk_done;
		logic [12:0] next_segment;
		logic        name_matched;
		logic [12:0] length_blocks;
		logic [11:0] start_block;
		logic [55:0] name_text;
		logic [1:0]  entry_kind;
	} result_t;

	function automatic logic [6:0] sixbit_char(input logic [5:0] c);
		logic [6:0] r;
		if (c == 6'd0)
			r = 7'd32;
		else if (c < 6'd32)
			r = {1'b0, c} + 7'd64;
		else
			r = {1'b0, c};
		return r;
	endfunction

	function automatic logic [55:0] decode_name(input logic [47:0] words);
		logic [55:0] text;
		text = '0;
		for (int k = 0; k < 8; k++) begin
			text[55 - 7 * k -: 7] = sixbit_char(words[47 - 6 * k -: 6]);
		end
		return text;
	endfunction

endpackage
`default_nettype wire

[rtl/core/sdsp_res_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdsp_res_fifo
// Small result queue: takes up to two results per cycle, hands one out on pop.
// ----------------------------------------------------------------------------
module sdsp_res_fifo (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [1:0]        push_cnt,
	input  wire sdsp_pkg::result_t push0,
	input  wire sdsp_pkg::result_t push1,
	input  wire logic              pop_ready,
	output logic                   out_valid,
	output sdsp_pkg::result_t      out_data,
	output logic                   room
);

	sdsp_pkg::result_t mem [sdsp_pkg::RES_DEPTH];

	logic [sdsp_pkg::PTR_W-1:0] wr_ptr_q;
	logic [sdsp_pkg::PTR_W-1:0] wr_ptr_nx;
	logic [sdsp_pkg::PTR_W-1:0] rd_ptr_q;
	logic [sdsp_pkg::CNT_W-1:0] count_q;
	logic                       pop;

	assign wr_ptr_nx = wr_ptr_q + sdsp_pkg::PTR_W'(1);
	assign out_valid = (count_q != '0);
	assign out_data  = mem[rd_ptr_q];
	assign pop       = out_valid & pop_ready;
	assign room      = (count_q <= sdsp_pkg::CNT_W'(sdsp_pkg::RES_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0)
			mem[wr_ptr_q] <= push0;
		if (push_cnt == 2'd2)
			mem[wr_ptr_nx] <= push1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + sdsp_pkg::PTR_W'(push_cnt);
			if (pop)
				rd_ptr_q <= rd_ptr_q + sdsp_pkg::PTR_W'(1);
			count_q <= count_q + sdsp_pkg::CNT_W'(push_cnt) - sdsp_pkg::CNT_W'(pop);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= sdsp_pkg::CNT_W'(sdsp_pkg::RES_DEPTH))
		else $error("result queue count out of range");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push_cnt != 2'd0) |-> (count_q <= sdsp_pkg::CNT_W'(sdsp_pkg::RES_DEPTH - 2)))
		else $error("result pushed without room");

	a_push_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		push_cnt != 2'd3)
		else $error("more than two results pushed");

endmodule
`default_nettype wire

[rtl/core/sixbit_directory_segment_parser_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sixbit_directory_segment_parser_core
// Walks directory segment words of a SIXBIT-named file system and emits one
// result per entry plus a segment-end result with the next segment link.
// ----------------------------------------------------------------------------
//  channel     dir  fields (low bit up)
//  s_axis      in   tdata: dir_word | tuser: segment_first, walk_start
//  m_axis      out  tdata: name_text, start_block, length_blocks, name_matched,
//                   next_segment, walk_done | tuser: entry_kind | tlast
//  wr_*        in   wr_index selects partition_offset, match_name, match_enable
//
//  one word accepted per cycle while s_axis_tready is high; results land in a
//  four-entry queue the cycle after acceptance and leave one per cycle while
//  m_axis_tready is high; a word that closes the last entry of a segment gives
//  two results, so a steady run of such words is paced by the single output port
//  s_axis_tready drops while the queue has fewer than two free slots
//  reset clears the walk state, the configuration and the queue
// ----------------------------------------------------------------------------
module sixbit_directory_segment_parser_core #(
	parameter int MAX_SEGMENTS = sdsp_pkg::MAX_SEGMENTS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr_en,
	input  wire logic [1:0]  wr_index,
	input  wire logic [47:0] wr_data,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // dir_word
	input  wire logic [1:0]  s_axis_tuser,  // segment_first, walk_start
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// name_text, start_block, length_blocks, name_matched, next_segment, walk_done
	output logic [95:0]      m_axis_tdata,
	output logic [1:0]       m_axis_tuser,  // entry_kind
	output logic             m_axis_tlast
);

	logic [11:0] partition_offset_q;
	logic [47:0] match_name_q;
	logic        match_enable_q;

	sdsp_pkg::phase_t phase_q, phase_d, ph0;
	logic [11:0] word_counter_q, wc_d, wc0, wc_inc, wc_dec;
	logic [11:0] entries_left_q, el_d, el_dec;
	logic [11:0] extra_words_q, ex_d;
	logic [11:0] running_block_q, rb_d;
	logic [47:0] name_words_q, nw_d;
	logic [11:0] segment_link_q, link_d;
	logic [2:0]  segment_count_q, sc_d, sc0;

	logic [11:0] w, neg_w;
	logic        first, start, restart, acc;
	logic        ent_fire, seg_fire, seg_done;
	logic [1:0]  ent_kind;
	logic [12:0] ent_len;
	logic [55:0] ent_text;
	logic        ent_match;
	logic [1:0]  push_cnt;
	logic        room;

	sdsp_pkg::result_t ent_res, seg_res, push0, push1, out_res;

	assign w       = s_axis_tdata[11:0];
	assign first   = s_axis_tuser[0];
	assign start   = s_axis_tuser[1];
	assign restart = start | first;
	assign neg_w   = 12'(13'h1000 - {1'b0, w});
	assign acc     = s_axis_tvalid & s_axis_tready;

	assign ph0    = restart ? sdsp_pkg::PH_HEADER : phase_q;
	assign wc0    = restart ? 12'd0 : word_counter_q;
	assign sc0    = start ? 3'd0 : segment_count_q;
	assign wc_inc = wc0 + 12'd1;
	assign wc_dec = wc0 - 12'd1;
	assign el_dec = entries_left_q - 12'd1;

	always_comb begin
		phase_d   = ph0;
		wc_d      = wc0;
		el_d      = entries_left_q;
		ex_d      = extra_words_q;
		rb_d      = running_block_q;
		nw_d      = name_words_q;
		link_d    = segment_link_q;
		sc_d      = sc0;
		ent_fire  = 1'b0;
		seg_fire  = 1'b0;
		ent_kind  = sdsp_pkg::KIND_FILE;
		ent_len   = '0;
		ent_text  = '0;
		ent_match = 1'b0;
		case (ph0)
			sdsp_pkg::PH_HEADER: begin
				if (wc0 == 12'd0)
					el_d = neg_w;
				if (wc0 == 12'd1)
					rb_d = w;
				if (wc0 == 12'd2)
					link_d = w;
				if (wc0 == 12'd4)
					ex_d = neg_w;
				wc_d = wc_inc;
				if (wc_inc >= 12'd5) begin
					wc_d = 12'd0;
					if (el_d == 12'd0)
						seg_fire = 1'b1;
					else
						phase_d = sdsp_pkg::PH_ENTRY;
				end
			end
			sdsp_pkg::PH_ENTRY: begin
				if (w == 12'd0) begin
					phase_d = sdsp_pkg::PH_EMPTY_LEN;
				end else begin
					nw_d    = {36'd0, w};
					wc_d    = 12'd1;
					phase_d = sdsp_pkg::PH_NAME;
				end
			end
			sdsp_pkg::PH_EMPTY_LEN: begin
				ent_fire = 1'b1;
				ent_kind = sdsp_pkg::KIND_EMPTY;
				ent_len  = 13'h1000 - {1'b0, w};
				rb_d     = running_block_q + ent_len[11:0];
				el_d     = el_dec;
				if (el_dec == 12'd0)
					seg_fire = 1'b1;
				else
					phase_d = sdsp_pkg::PH_ENTRY;
			end
			sdsp_pkg::PH_NAME: begin
				nw_d = {name_words_q[35:0], w};
				wc_d = wc_inc;
				if (wc_inc >= 12'd4) begin
					wc_d    = extra_words_q;
					phase_d = (extra_words_q == 12'd0) ? sdsp_pkg::PH_LENGTH
						: sdsp_pkg::PH_EXTRA;
				end
			end
			sdsp_pkg::PH_EXTRA: begin
				wc_d = wc_dec;
				if (wc_dec == 12'd0)
					phase_d = sdsp_pkg::PH_LENGTH;
			end
			sdsp_pkg::PH_LENGTH: begin
				ent_fire  = 1'b1;
				ent_kind  = sdsp_pkg::KIND_FILE;
				ent_len   = {1'b0, neg_w};
				ent_text  = sdsp_pkg::decode_name(name_words_q);
				ent_match = match_enable_q & (name_words_q == match_name_q);
				rb_d      = running_block_q + neg_w;
				el_d      = el_dec;
				if (el_dec == 12'd0)
					seg_fire = 1'b1;
				else
					phase_d = sdsp_pkg::PH_ENTRY;
			end
			default: begin
			end
		endcase
		if (seg_fire) begin
			sc_d    = (sc0 < 3'd7) ? sc0 + 3'd1 : sc0;
			phase_d = sdsp_pkg::PH_IDLE;
		end
	end

	assign seg_done = (link_d == 12'd0) || (sc_d >= 3'(MAX_SEGMENTS));

	always_comb begin
		ent_res               = '0;
		ent_res.entry_kind    = ent_kind;
		ent_res.name_text     = ent_text;
		ent_res.start_block   = running_block_q;
		ent_res.length_blocks = ent_len;
		ent_res.name_matched  = ent_match;
		ent_res.last          = ~seg_fire;

		seg_res              = '0;
		seg_res.entry_kind   = sdsp_pkg::KIND_SEG_END;
		seg_res.next_segment = {1'b0, link_d} + {1'b0, partition_offset_q};
		seg_res.walk_done    = seg_done;
		seg_res.last         = 1'b1;

		push0 = ent_fire ? ent_res : seg_res;
		push1 = seg_res;
	end

	assign push_cnt = acc ? (2'(ent_fire) + 2'(seg_fire)) : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partition_offset_q <= '0;
			match_name_q       <= '0;
			match_enable_q     <= 1'b0;
		end else if (wr_en) begin
			case (wr_index)
				sdsp_pkg::CFG_PARTITION_OFFSET: partition_offset_q <= wr_data[11:0];
				sdsp_pkg::CFG_MATCH_NAME:       match_name_q       <= wr_data;
				sdsp_pkg::CFG_MATCH_ENABLE:     match_enable_q     <= wr_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= sdsp_pkg::PH_HEADER;
			word_counter_q  <= '0;
			entries_left_q  <= '0;
			extra_words_q   <= '0;
			running_block_q <= '0;
			name_words_q    <= '0;
			segment_link_q  <= '0;
			segment_count_q <= '0;
		end else if (acc) begin
			phase_q         <= phase_d;
			word_counter_q  <= wc_d;
			entries_left_q  <= el_d;
			extra_words_q   <= ex_d;
			running_block_q <= rb_d;
			name_words_q    <= nw_d;
			segment_link_q  <= link_d;
			segment_count_q <= sc_d;
		end
	end

	sdsp_res_fifo u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (push_cnt),
		.push0     (push0),
		.push1     (push1),
		.pop_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (out_res),
		.room      (room)
	);

	assign s_axis_tready = room;
	assign m_axis_tdata  = {out_res.walk_done, out_res.next_segment, out_res.name_matched,
		out_res.length_blocks, out_res.start_block, out_res.name_text};
	assign m_axis_tuser  = out_res.entry_kind;
	assign m_axis_tlast  = out_res.last;

	a_header_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == sdsp_pkg::PH_HEADER) |-> (word_counter_q < 12'd5))
		else $error("header word counter past header");

	a_seg_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && seg_fire) |=> (phase_q == sdsp_pkg::PH_IDLE))
		else $error("segment end not followed by idle phase");

	a_seg_count_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !start) |=> (segment_count_q >= $past(segment_count_q)))
		else $error("segment count went down without walk start");

endmodule
`default_nettype wire

[test/sixbit_directory_segment_parser_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sixbit_directory_segment_parser_core_tb
// Streams directory segment words into the parser and checks every entry and
// segment-end record against a cycle-free model of the segment walk. Runs a
// short hand-built walk, then random walks with random content, some broken
// segments and stray words, under five register settings and random stalls
// on both streams in all but the second.
// ----------------------------------------------------------------------------
module sixbit_directory_segment_parser_core_tb;
	import sdsp_pkg::*;

	localparam int SEG_LIMIT = MAX_SEGMENTS_DEF;
	localparam int PHASE_WORDS = 360;
	localparam logic [47:0] NAME_MIX = {12'o0001, 12'o3740, 12'o7720, 12'o4142};

	typedef struct {
		logic [11:0] word;
		logic first;
		logic start;
		logic hold;
	} dir_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [1:0] wr_index = CFG_PARTITION_OFFSET;
	logic [47:0] wr_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [15:0] s_axis_tdata = '0;  // dir_word
	logic [1:0] s_axis_tuser = '0;   // segment_first, walk_start
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	// name_text, start_block, length_blocks, name_matched, next_segment, walk_done
	logic [95:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;        // entry_kind
	logic m_axis_tlast;

	dir_item_t word_queue[$];
	result_t awaited_records[$];
	int words_queued = 0;
	int fault_count = 0;
	bit steady = 1'b0;
	logic [47:0] gen_match = '0;

	// walk state as the parser should hold it
	phase_t walk_phase = PH_HEADER;
	logic [11:0] word_cnt = '0;
	logic [11:0] entries_left = '0;
	logic [11:0] extra_cnt = '0;
	logic [11:0] run_block = '0;
	logic [47:0] name_acc = '0;
	logic [11:0] seg_link = '0;
	logic [2:0] seg_cnt = '0;
	logic [11:0] cfg_offset = '0;
	logic [47:0] cfg_name = '0;
	logic cfg_enable = 1'b0;

	always #2 clk = ~clk;

	sixbit_directory_segment_parser_core #(
		.MAX_SEGMENTS(SEG_LIMIT)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	function automatic logic [55:0] name_to_ascii(logic [47:0] words);
		logic [55:0] text;
		logic [5:0] six;
		text = '0;
		for (int k = 0; k < 8; k++) begin
			six = words[47 - 6 * k -: 6];
			text = text << 7;
			if (six == 6'd0)
				text[6:0] = 7'd32;
			else if (six < 6'd32)
				text[6:0] = {1'b0, six} + 7'd64;
			else
				text[6:0] = {1'b0, six};
		end
		return text;
	endfunction

	function automatic result_t make_record(logic [1:0] kind, logic [55:0] text,
			logic [11:0] blk, logic [12:0] len, logic hit, logic [12:0] nxt,
			logic fin);
		result_t r;
		r.entry_kind = kind;
		r.name_text = text;
		r.start_block = blk;
		r.length_blocks = len;
		r.name_matched = hit;
		r.next_segment = nxt;
		r.walk_done = fin;
		r.last = 1'b0;
		return r;
	endfunction

	function automatic result_t close_segment();
		logic fin;
		if (seg_cnt < 3'd7)
			seg_cnt = seg_cnt + 3'd1;
		fin = (seg_link == 12'd0) || (int'(seg_cnt) >= SEG_LIMIT);
		walk_phase = PH_IDLE;
		return make_record(KIND_SEG_END, '0, '0, '0, 1'b0,
			{1'b0, seg_link} + {1'b0, cfg_offset}, fin);
	endfunction

	// true when the entry just finished was the last of its segment
	function automatic bit finish_entry();
		entries_left = entries_left - 12'd1;
		if (entries_left == 12'd0)
			return 1'b1;
		walk_phase = PH_ENTRY;
		return 1'b0;
	endfunction

	task automatic walk_dir_word(logic [11:0] w, logic first, logic start);
		result_t recs[2];
		result_t rec;
		int n;
		logic [12:0] len;
		logic hit;
		n = 0;
		if (start)
			seg_cnt = '0;
		if (start || first) begin
			walk_phase = PH_HEADER;
			word_cnt = '0;
		end
		case (walk_phase)
			PH_HEADER: begin
				if (word_cnt == 12'd0)
					entries_left = 12'd0 - w;
				else if (word_cnt == 12'd1)
					run_block = w;
				else if (word_cnt == 12'd2)
					seg_link = w;
				else if (word_cnt == 12'd4)
					extra_cnt = 12'd0 - w;
				word_cnt = word_cnt + 12'd1;
				if (word_cnt >= 12'd5) begin
					word_cnt = '0;
					if (entries_left == 12'd0) begin
						recs[n] = close_segment();
						n++;
					end else begin
						walk_phase = PH_ENTRY;
					end
				end
			end
			PH_ENTRY: begin
				if (w == 12'd0) begin
					walk_phase = PH_EMPTY_LEN;
				end else begin
					name_acc = {36'd0, w};
					word_cnt = 12'd1;
					walk_phase = PH_NAME;
				end
			end
			PH_EMPTY_LEN: begin
				len = 13'd4096 - {1'b0, w};
				recs[n] = make_record(KIND_EMPTY, '0, run_block, len, 1'b0, '0, 1'b0);
				n++;
				run_block = run_block + len[11:0];
				if (finish_entry()) begin
					recs[n] = close_segment();
					n++;
				end
			end
			PH_NAME: begin
				name_acc = {name_acc[35:0], w};
				word_cnt = word_cnt + 12'd1;
				if (word_cnt >= 12'd4) begin
					word_cnt = extra_cnt;
					walk_phase = (extra_cnt == 12'd0) ? PH_LENGTH : PH_EXTRA;
				end
			end
			PH_EXTRA: begin
				word_cnt = word_cnt - 12'd1;
				if (word_cnt == 12'd0)
					walk_phase = PH_LENGTH;
			end
			PH_LENGTH: begin
				len = {1'b0, 12'd0 - w};
				hit = cfg_enable && (name_acc == cfg_name);
				recs[n] = make_record(KIND_FILE, name_to_ascii(name_acc), run_block, len,
					hit, '0, 1'b0);
				n++;
				run_block = run_block + len[11:0];
				if (finish_entry()) begin
					recs[n] = close_segment();
					n++;
				end
			end
			default: begin
			end
		endcase
		for (int i = 0; i < n; i++) begin
			rec = recs[i];
			rec.last = (i == n - 1);
			awaited_records.insert(awaited_records.size(), rec);
		end
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin : drive_words
		dir_item_t it;
		bit blocked;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			blocked = (word_queue.size() == 0);
			if (!blocked && word_queue[0].hold)
				blocked = s_axis_tvalid || (awaited_records.size() != 0);
			if (!blocked && (steady || $urandom_range(99) >= 38)) begin
				it = word_queue.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {4'd0, it.word};
				s_axis_tuser <= {it.start, it.first};
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver, register snoop and record check
	always @(posedge clk or negedge arst_n) begin : watch_records
		result_t got;
		result_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= steady || ($urandom_range(99) >= 38);
			if (m_axis_tvalid && m_axis_tready) begin
				got.entry_kind = m_axis_tuser;
				got.name_text = m_axis_tdata[55:0];
				got.start_block = m_axis_tdata[67:56];
				got.length_blocks = m_axis_tdata[80:68];
				got.name_matched = m_axis_tdata[81];
				got.next_segment = m_axis_tdata[94:82];
				got.walk_done = m_axis_tdata[95];
				got.last = m_axis_tlast;
				if (awaited_records.size() == 0) begin
					fault_count++;
					if (fault_count <= 10)
						$display("%0t: unexpected record kind %0d start %h len %h next %h",
							$realtime, got.entry_kind, got.start_block, got.length_blocks,
							got.next_segment);
				end else begin
					want = awaited_records.pop_front();
					if (got !== want) begin
						fault_count++;
						if (fault_count <= 10) begin
							$display("%0t: record mismatch", $realtime);
							$display("  expected kind %0d name %h start %h len %h hit %b next %h done %b last %b",
								want.entry_kind, want.name_text, want.start_block,
								want.length_blocks, want.name_matched, want.next_segment,
								want.walk_done, want.last);
							$display("  actual   kind %0d name %h start %h len %h hit %b next %h done %b last %b",
								got.entry_kind, got.name_text, got.start_block,
								got.length_blocks, got.name_matched, got.next_segment,
								got.walk_done, got.last);
						end
					end
				end
			end
			if (wr_en) begin
				case (wr_index)
					CFG_PARTITION_OFFSET: cfg_offset = wr_data[11:0];
					CFG_MATCH_NAME: cfg_name = wr_data;
					CFG_MATCH_ENABLE: cfg_enable = wr_data[0];
					default: begin
					end
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				walk_dir_word(s_axis_tdata[11:0], s_axis_tuser[0], s_axis_tuser[1]);
		end
	end

	function automatic void push_word(logic [11:0] w, logic first, logic start, logic hold);
		dir_item_t it;
		it.word = w;
		it.first = first;
		it.start = start;
		it.hold = hold;
		word_queue.insert(word_queue.size(), it);
		words_queued++;
	endfunction

	function automatic logic [47:0] pick_name();
		if ($urandom_range(3) == 0 && gen_match[47:36] != 12'd0)
			return gen_match;
		return {12'($urandom_range(4095, 1)), 4'($urandom), $urandom};
	endfunction

	function automatic logic [11:0] pick_length();
		if ($urandom_range(19) == 0)
			return ($urandom_range(1) != 0) ? 12'd0 : 12'd4095;
		return 12'($urandom);
	endfunction

	task automatic add_segment(bit start, logic [11:0] link);
		int n;
		int x;
		logic [47:0] nm;
		n = ($urandom_range(9) == 0) ? 0 : $urandom_range(5, 1);
		x = ($urandom_range(9) < 4) ? 0 : $urandom_range(3, 1);
		push_word(12'(4096 - n), start ? 1'($urandom_range(1)) : 1'b1, start,
			$urandom_range(29) == 0);
		push_word(12'($urandom), 1'b0, 1'b0, 1'b0);
		push_word(link, 1'b0, 1'b0, 1'b0);
		push_word(12'($urandom), 1'b0, 1'b0, 1'b0);
		push_word(12'(4096 - x), 1'b0, 1'b0, 1'b0);
		for (int e = 0; e < n; e++) begin
			// cut the segment short, the next mark restarts the header
			if ($urandom_range(24) == 0) begin
				push_word(12'($urandom_range(4095, 1)), 1'b0, 1'b0, 1'b0);
				return;
			end
			if ($urandom_range(9) < 3) begin
				push_word(12'd0, 1'b0, 1'b0, 1'b0);
				push_word(pick_length(), 1'b0, 1'b0, 1'b0);
			end else begin
				nm = pick_name();
				for (int k = 0; k < 4; k++)
					push_word(nm[47 - 12 * k -: 12], 1'b0, 1'b0, 1'b0);
				for (int k = 0; k < x; k++)
					push_word(12'($urandom), 1'b0, 1'b0, 1'b0);
				push_word(pick_length(), 1'b0, 1'b0, 1'b0);
			end
		end
	endtask

	task automatic add_walk();
		int segs;
		logic [11:0] link;
		segs = $urandom_range(8, 1);
		for (int s = 0; s < segs; s++) begin
			if (s == segs - 1 && $urandom_range(1) != 0)
				link = 12'd0;
			else
				link = 12'($urandom_range(4095, 1));
			add_segment(s == 0, link);
			// stray words after a segment end are dropped
			if ($urandom_range(9) == 0)
				push_word(12'($urandom), 1'b0, 1'b0, 1'b0);
		end
	endtask

	task automatic add_random_words(int count);
		int mark;
		mark = words_queued;
		while (words_queued - mark < count) begin
			if ($urandom_range(9) == 0)
				push_word(12'($urandom), $urandom_range(19) == 0, $urandom_range(29) == 0,
					1'b0);
			else
				add_walk();
		end
	endtask

	task automatic write_register(logic [1:0] idx, logic [47:0] value);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic load_settings(logic [11:0] offset, logic [47:0] nm, logic enable);
		write_register(CFG_PARTITION_OFFSET, {36'd0, offset});
		write_register(CFG_MATCH_NAME, nm);
		write_register(CFG_MATCH_ENABLE, {47'd0, enable});
		gen_match = nm;
		@(negedge clk);
	endtask

	// wait until every queued word went in and every record came out
	task automatic drain();
		@(negedge clk);
		while (word_queue.size() != 0 || s_axis_tvalid || awaited_records.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		load_settings(12'd3248, NAME_MIX, 1'b1);
		// unmarked first word is header word 0: two entries, block 4095, null link
		push_word(12'd4094, 1'b0, 1'b0, 1'b0);
		push_word(12'd4095, 1'b0, 1'b0, 1'b0);
		push_word(12'd0, 1'b0, 1'b0, 1'b0);
		push_word(12'd4095, 1'b0, 1'b0, 1'b0);
		push_word(12'd0, 1'b0, 1'b0, 1'b0);
		// empty entry of 4096 blocks, start block wraps
		push_word(12'd0, 1'b0, 1'b0, 1'b0);
		push_word(12'd0, 1'b0, 1'b0, 1'b0);
		// matching file, zero length closes the segment
		for (int k = 0; k < 4; k++)
			push_word(NAME_MIX[47 - 12 * k -: 12], 1'b0, 1'b0, 1'b0);
		push_word(12'd0, 1'b0, 1'b0, 1'b0);
		push_word(12'd4095, 1'b0, 1'b0, 1'b0);
		// one entry with one extra word, name one bit off
		push_word(12'd4095, 1'b1, 1'b0, 1'b0);
		push_word(12'd0, 1'b0, 1'b0, 1'b0);
		push_word(12'd4095, 1'b0, 1'b0, 1'b0);
		push_word(12'd0, 1'b0, 1'b0, 1'b0);
		push_word(12'd4095, 1'b0, 1'b0, 1'b0);
		for (int k = 0; k < 3; k++)
			push_word(NAME_MIX[47 - 12 * k -: 12], 1'b0, 1'b0, 1'b0);
		push_word(NAME_MIX[11:0] ^ 12'd1, 1'b0, 1'b0, 1'b0);
		push_word(12'd0, 1'b0, 1'b0, 1'b0);
		push_word(12'd1, 1'b0, 1'b0, 1'b0);
		// new walk, segment without entries
		push_word(12'd0, 1'b0, 1'b1, 1'b1);
		push_word(12'd1, 1'b0, 1'b0, 1'b0);
		push_word(12'd5, 1'b0, 1'b0, 1'b0);
		push_word(12'd0, 1'b0, 1'b0, 1'b0);
		push_word(12'd0, 1'b0, 1'b0, 1'b0);
		add_random_words(PHASE_WORDS - 30);
		drain();

		load_settings(12'd4095, {48{1'b1}}, 1'b1);
		steady = 1'b1;
		add_random_words(PHASE_WORDS);
		drain();
		steady = 1'b0;

		load_settings(12'd0, 48'd0, 1'b0);
		add_random_words(PHASE_WORDS);
		drain();

		load_settings(12'($urandom), {12'($urandom_range(4095, 1)), 4'($urandom), $urandom},
			1'b1);
		add_random_words(PHASE_WORDS);
		drain();

		load_settings(12'd4095, {12'($urandom_range(4095, 1)), 4'($urandom), $urandom},
			1'b0);
		add_random_words(PHASE_WORDS);
		drain();

		if (fault_count == 0 && awaited_records.size() == 0)
			$display("sixbit_directory_segment_parser_core_tb: done, clean");
		else
			$display("sixbit_directory_segment_parser_core_tb: done, errors");
		$finish;
	end

	initial begin
		#2000000;
		$display("sixbit_directory_segment_parser_core_tb: done, errors");
		$finish;
	end

endmodule

[sim.f]
rtl/core/sdsp_pkg.sv
rtl/core/sdsp_res_fifo.sv
rtl/core/sixbit_directory_segment_parser_core.sv
test/sixbit_directory_segment_parser_core_tb.sv
